>>> sv/per_source_cooldown_filter_macros.svh
// Shared assertion macros for the cooldown filter.
// All checks sample on the rising edge of clock and are off while reset is high.
`ifndef PER_SOURCE_COOLDOWN_FILTER_MACROS_SVH
`define PER_SOURCE_COOLDOWN_FILTER_MACROS_SVH

// Same-cycle implication.
`define PSCF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PSCF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pscf_pkg.sv
package pscf_pkg;

   // Number of remembered sources and width of a slot index
   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int SRC_W  = 32;
   localparam int TIME_W = 32;
   localparam int CD_W   = 16;

   localparam logic [CD_W-1:0] COOLDOWN_RESET = 16'd1000;

   // Input beat
   typedef struct packed {
      logic [SRC_W-1:0]  source_id;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   // Result beat
   typedef struct packed {
      logic limited;
      logic was_known;
   } rsp_type;

   // One lookup handed to the slot table
   typedef struct packed {
      logic              valid;
      logic [SRC_W-1:0]  source_id;
      logic [TIME_W-1:0] now_ms;
      logic [CD_W-1:0]   cooldown_ms;
   } lookup_type;

endpackage

>>> sv/pscf_slot_table.sv
module pscf_slot_table (
   input  logic                clock,
   input  logic                reset,
   input  pscf_pkg::lookup_type lookup,
   output pscf_pkg::rsp_type    result
);
   import pscf_pkg::*;

   `include "per_source_cooldown_filter_macros.svh"

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [SRC_W-1:0]  slot_source_ff [SLOTS];
   logic [TIME_W-1:0] slot_time_ff   [SLOTS];
   logic [SLOTS-1:0]  slot_valid_ff;
   logic [SLOTS-1:0]  slot_valid_in;
   logic [IDX_W-1:0]  ptr_ff;
   logic [IDX_W-1:0]  ptr_in;

   logic [SLOTS-1:0]  hit_vec;
   logic              hit_any;
   logic [IDX_W-1:0]  hit_idx;
   logic [TIME_W-1:0] elapsed;
   logic              in_cooldown;
   logic [SLOTS-1:0]  time_wr;
   logic [SLOTS-1:0]  src_wr;

   // Compare every valid slot with the incoming source
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i] = slot_valid_ff[i] && (slot_source_ff[i] == lookup.source_id);
      end
   end

   // Pick the lowest-numbered matching slot
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   // Wrapping elapsed time against the cooldown
   assign elapsed     = lookup.now_ms - slot_time_ff[hit_idx];
   assign in_cooldown = elapsed < {{(TIME_W - CD_W){1'b0}}, lookup.cooldown_ms};

   // Refresh the matching slot when its cooldown has passed; on a miss fill the slot under the pointer
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         src_wr[i]  = lookup.valid && !hit_any && (ptr_ff == IDX_W'(i));
         time_wr[i] = src_wr[i] ||
                      (lookup.valid && hit_any && !in_cooldown && (hit_idx == IDX_W'(i)));
         slot_valid_in[i] = slot_valid_ff[i] || src_wr[i];
      end
   end

   // Advance the replacement pointer round-robin on insertion
   always_comb begin
      ptr_in = ptr_ff;
      if (lookup.valid && !hit_any) begin
         ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
      end
   end

   assign result.limited   = hit_any && in_cooldown;
   assign result.was_known = hit_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         ptr_ff        <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         ptr_ff        <= ptr_in;
      end
   end

   // Slot payload needs no reset: invalid slots never match
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (src_wr[i]) begin
            slot_source_ff[i] <= lookup.source_id;
         end
         if (time_wr[i]) begin
            slot_time_ff[i] <= lookup.now_ms;
         end
      end
   end

   `PSCF_ASSERT_IMP(a_one_slot_written, 1'b1, $onehot0(time_wr), "more than one slot written")
   `PSCF_ASSERT_NXT(a_ptr_holds_on_hit, !(lookup.valid && !hit_any), $stable(ptr_ff), "pointer moved without insertion")
   `PSCF_ASSERT_NXT(a_insert_sets_valid, lookup.valid && !hit_any, slot_valid_ff[$past(ptr_ff)], "inserted slot not valid")

endmodule

>>> sv/per_source_cooldown_filter.sv
// Per-source cooldown filter.
// Request channel (req_valid / req_stall / req_data) carries a source ID and a
// millisecond timestamp; a beat is taken when req_valid is high and req_stall
// is low. Result channel (rsp_valid / rsp_stall / rsp_data) returns one beat
// per request, in order: limited (drop it) and was_known (source was in the
// table). The cooldown register is written through csr_valid / csr_ready /
// csr_data while no request waits in the input register.
// A request taken at a clock edge waits in the input register; its result is
// captured in the result register once that is free. Throughput is one request
// per cycle while rsp_stall holds no result: the whole lookup, the slot compare
// of all entries and the table update sit between the input register and the
// result register, and the table update lands in time for the following request.
// Reset clears all slot valid bits, the replacement pointer and the valid bits
// of both pipeline registers, and loads a cooldown of 1000 ms.
// While rsp_stall holds a waiting result, the request in the input register
// waits as well and req_stall rises; one further request can still be taken
// when the input register is empty.
module per_source_cooldown_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pscf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pscf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import pscf_pkg::*;

   `include "per_source_cooldown_filter_macros.svh"

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_type         s1_req_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_data_ff;
   logic [CD_W-1:0] cooldown_ff;
   logic [CD_W-1:0] cooldown_in;
   logic            advance;
   logic            req_take;
   lookup_type      lookup;
   rsp_type         result;

   // Move the input beat forward when the result register is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !s1_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      cooldown_in  = (csr_valid && csr_ready) ? csr_data : cooldown_ff;
   end

   assign lookup.valid       = s1_valid_ff && advance;
   assign lookup.source_id   = s1_req_ff.source_id;
   assign lookup.now_ms      = s1_req_ff.now_ms;
   assign lookup.cooldown_ms = cooldown_ff;

   pscf_slot_table u_table (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cooldown_ff  <= COOLDOWN_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cooldown_ff  <= cooldown_in;
      end
   end

   // Capture the request beat and the result beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (lookup.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PSCF_ASSERT_IMP(a_limited_known, rsp_valid_ff, !rsp_data_ff.limited || rsp_data_ff.was_known, "limited result for unknown source")
   `PSCF_ASSERT_NXT(a_lookup_to_rsp, lookup.valid, rsp_valid_ff, "lookup did not produce a result")
   `PSCF_ASSERT_IMP(a_stall_needs_item, req_stall, s1_valid_ff && rsp_valid_ff, "stall with empty input register")

endmodule

>>> verif/tb_per_source_cooldown_filter.sv
module tb_per_source_cooldown_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import pscf_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CD_W-1:0]   csr_data = '0;

   // Shadow of the slot table and the cooldown register
   bit [SRC_W-1:0]  shadow_source [SLOTS];
   bit [TIME_W-1:0] shadow_stamp [SLOTS];
   bit              shadow_live [SLOTS];
   int unsigned     shadow_victim;
   bit [CD_W-1:0]   shadow_cooldown;

   // Verdicts predicted for accepted requests, oldest first
   rsp_type         pending_verdicts [$];
   int unsigned     error_count = 0;

   // Knobs shared by the test tasks and the two handshake sides
   bit              req_gaps_on = 1'b0;
   bit              rsp_stalls_on = 1'b0;
   int unsigned     hold_request = 0;

   per_source_cooldown_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < SLOTS; i++) begin
         shadow_source[i] = '0;
         shadow_stamp[i]  = '0;
         shadow_live[i]   = 1'b0;
      end
      shadow_victim   = 0;
      shadow_cooldown = COOLDOWN_RESET;
   endfunction

   // Look up the source, apply the cooldown and update the shadow table
   function automatic rsp_type predict_verdict(req_type item);
      rsp_type         verdict;
      bit [TIME_W-1:0] elapsed;
      verdict = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && shadow_source[i] == item.source_id) begin
            elapsed = item.now_ms - shadow_stamp[i];
            if (elapsed < TIME_W'(shadow_cooldown)) begin
               verdict.limited = 1'b1;
            end else begin
               shadow_stamp[i] = item.now_ms;
            end
            verdict.was_known = 1'b1;
            return verdict;
         end
      end
      // Unknown source: take the slot under the round-robin pointer
      shadow_source[shadow_victim] = item.source_id;
      shadow_stamp[shadow_victim]  = item.now_ms;
      shadow_live[shadow_victim]   = 1'b1;
      shadow_victim = (shadow_victim + 1 >= SLOTS) ? 0 : shadow_victim + 1;
      return verdict;
   endfunction

   // Offer one request beat and hold it until the block takes it
   task automatic offer_request(input bit [SRC_W-1:0] source, input bit [TIME_W-1:0] stamp);
      req_type     item;
      int unsigned gap;
      item.source_id = source;
      item.now_ms    = stamp;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(predict_verdict(item));
   endtask

   // Stop offering and wait until every predicted verdict has come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cooldown(input bit [CD_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_cooldown = value;
   endtask

   // Result side: random stalls, plus a long hold when a test asks for one
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no request pending: %b", rsp_data);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.limited !== want.limited) begin
               $error("limited: expected %b, got %b", want.limited, rsp_data.limited);
               error_count++;
            end
            if (rsp_data.was_known !== want.was_known) begin
               $error("was_known: expected %b, got %b", want.was_known, rsp_data.was_known);
               error_count++;
            end
         end
      end
   end

   // Reset cooldown of 1000 ms; an empty slot holding zeros must not match source 0
   task automatic test_default_cooldown();
      offer_request(32'h0000_0000, 32'h0000_0000);
      offer_request(32'h0000_0000, 32'd999);
      offer_request(32'h0000_0000, 32'd1000);
      offer_request(32'hA5A5_0001, 32'd50);
      offer_request(32'hA5A5_0001, 32'd1049);
   endtask

   // Fill the table past its size so the pointer wraps and evicts old sources
   task automatic test_slot_replacement();
      for (int i = 0; i < SLOTS + 1; i++) begin
         offer_request(32'h1000_0000 + i, 32'd5000);
      end
      offer_request(32'h0000_0000, 32'd5000);
   endtask

   // Timer wrap, timestamps running backwards and all-ones fields
   task automatic test_timer_wrap();
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FF00);
      offer_request(32'hFFFF_FFFF, 32'h0000_0010);
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FE00);
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // No request is ever limited with a zero cooldown
   task automatic test_zero_cooldown();
      write_cooldown('0);
      offer_request(32'h0BAD_CAFE, 32'd7);
      offer_request(32'h0BAD_CAFE, 32'd7);
      offer_request(32'h0BAD_CAFE, 32'd7);
   endtask

   // Largest cooldown: one tick short is limited, the full span passes
   task automatic test_max_cooldown();
      write_cooldown('1);
      offer_request(32'h7E57_0000, 32'd100);
      offer_request(32'h7E57_0000, 32'd100 + 32'd65534);
      offer_request(32'h7E57_0000, 32'd100 + 32'd65535);
   endtask

   // Hold the result side while requests keep coming, so the input backs up
   task automatic test_result_hold();
      write_cooldown(16'd20);
      req_gaps_on  = 1'b0;
      hold_request = 50;
      for (int i = 0; i < 12; i++) begin
         offer_request(32'h3000_0000 + (i % 5), 32'd10 * i);
      end
      drain_pipeline();
   endtask

   // Well-formed traffic from a pool of sources, with noise and clock jumps
   task automatic test_random_traffic(input int unsigned total);
      bit [SRC_W-1:0]  pool [16];
      int unsigned     pool_size;
      bit [CD_W-1:0]   cooldown;
      bit [SRC_W-1:0]  source;
      bit [TIME_W-1:0] stamp;
      int unsigned     r;
      stamp = $urandom();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       cooldown = CD_W'($urandom_range(1, 40));
            1:       cooldown = '1;
            2:       cooldown = '0;
            3:       cooldown = CD_W'($urandom());
            default: cooldown = COOLDOWN_RESET;
         endcase
         write_cooldown(cooldown);
         pool_size = $urandom_range(3, 14);
         for (int i = 0; i < pool_size; i++) begin
            pool[i] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom();
         end
         for (int n = 0; n < total / 5; n++) begin
            // Switch idling on and off in stretches
            if (n % 25 == 0) begin
               req_gaps_on   = ($urandom_range(0, 3) != 0);
               rsp_stalls_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
               source = pool[$urandom_range(0, pool_size - 1)];
               stamp  = stamp + $urandom_range(0, cooldown / 4 + 2);
            end else if (r < 92) begin
               source = $urandom();
               stamp  = $urandom();
            end else begin
               source = pool[$urandom_range(0, pool_size - 1)];
               stamp  = stamp - $urandom_range(1, cooldown + 5);
            end
            offer_request(source, stamp);
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      clear_shadow();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_cooldown();
      test_slot_replacement();
      test_timer_wrap();
      test_zero_cooldown();
      test_max_cooldown();
      test_result_hold();
      test_random_traffic(500);

      drain_pipeline();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/pscf_pkg.sv
sv/pscf_slot_table.sv
sv/per_source_cooldown_filter.sv
verif/tb_per_source_cooldown_filter.sv
